// ----- rtl/core/bpa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared widths, codes and controller/datapath interface types of the
// bitmap page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

  // Field widths
  localparam int CNT_W  = 17;
  localparam int PAGE_W = 16;

  // Defaults
  localparam int MAX_PAGES_DEF = 65536;
  localparam int TOTAL_RST     = 65536;

  // Command codes
  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } bpa_op_t;

  // Controller to datapath commands
  typedef struct packed {
    logic scan_start;   // start a search at the cursor
    logic scan_retry;   // wrap the cursor to zero, search again
    logic scan_step;    // advance the run or the cursor by one probe
    logic scan_hit;     // run found: record it and arm the mark walk
    logic cursor_zero;  // zero-count allocate: clear cursor, report failure
    logic fill_free;    // arm the free walk from the input transaction
    logic fill_step;    // write one bitmap entry and advance the walk
    logic res_fail;     // report a failed allocation
    logic load_out;     // move the result into the output register
  } bpa_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_fail;    // cursor at or beyond the effective total
    logic scan_hit;     // probed page free and run reaches count
    logic fill_end;     // walk pointer at or beyond the map size
    logic rem_zero;     // walk has no pages left
    logic cnt_zero;     // input count is zero
    logic out_free;     // output register can take a result
  } bpa_sts_t;

endpackage

// ----- rtl/core/bitmap_page_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_page_allocator
// Next-fit page allocator over a used/free bitmap of physical pages, with a
// search cursor, one wrap-around retry and free commands for page runs.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake           payload
//  in_      input      in_valid/in_stall   in_cmd, in_page_index, in_count
//  out_     output     out_valid/out_stall out_ok, out_base_page
//  cfg_     input      cfg_valid/cfg_ready cfg_total_pages
//
//  One transaction at a time. The search probes one page per cycle from
//  the bitmap memory's single read port; an allocate that finds a run then
//  writes its pages, and a wrap adds one retry pass from page zero. A free
//  writes its run of pages, and a zero count answers with a failure.
//  After reset a clearing pass marks all MAX_PAGES pages used, with
//  in_stall high; cfg writes are taken throughout.
//  A result waits in the output register while the next transaction starts.
//
module bitmap_page_allocator #(
  parameter int MAX_PAGES = bpa_pkg::MAX_PAGES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [bpa_pkg::CNT_W-1:0]  cfg_total_pages,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_cmd,
  input  logic [bpa_pkg::PAGE_W-1:0] in_page_index,
  input  logic [bpa_pkg::CNT_W-1:0]  in_count,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_ok,
  output logic [bpa_pkg::PAGE_W-1:0] out_base_page
);
  import bpa_pkg::*;

  bpa_cmd_t cmd;
  bpa_sts_t sts;

  // Total register is written whenever offered
  assign cfg_ready = 1'b1;

  bpa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  bpa_dp #(
    .MAX_PAGES (MAX_PAGES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_total_pages (cfg_total_pages),
    .in_page_index   (in_page_index),
    .in_count        (in_count),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_ok          (out_ok),
    .out_base_page   (out_base_page),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule

// ----- rtl/core/bpa_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_ctrl
// Sequencer of the page allocator: clearing pass, next-fit search with one
// retry, bitmap write walk and result handoff.
// ----------------------------------------------------------------------------
module bpa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_cmd,
  output logic              in_stall,
  input  bpa_pkg::bpa_sts_t sts,
  output bpa_pkg::bpa_cmd_t cmd
);
  import bpa_pkg::*;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_FILL  = 5'b01000,
    ST_RESP  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   pass_r, pass_nxt;

  // Take a transaction only between commands
  assign in_stall = (state_r != ST_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    pass_nxt  = pass_r;
    cmd       = '0;
    unique case (state_r)
      ST_CLEAR: begin
        if (sts.fill_end) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.fill_step = 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (in_cmd == CMD_FREE) begin
            cmd.fill_free = 1'b1;
            state_nxt     = ST_FILL;
          end else if (sts.cnt_zero) begin
            cmd.cursor_zero = 1'b1;
            state_nxt       = ST_RESP;
          end else begin
            cmd.scan_start = 1'b1;
            pass_nxt       = 1'b0;
            state_nxt      = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (sts.scan_fail) begin
          if (!pass_r) begin
            cmd.scan_retry = 1'b1;
            pass_nxt       = 1'b1;
          end else begin
            cmd.res_fail = 1'b1;
            state_nxt    = ST_RESP;
          end
        end else if (sts.scan_hit) begin
          cmd.scan_hit = 1'b1;
          state_nxt    = ST_FILL;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_FILL: begin
        if (sts.rem_zero || sts.fill_end) begin
          state_nxt = ST_RESP;
        end else begin
          cmd.fill_step = 1'b1;
        end
      end
      ST_RESP: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      pass_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pass_r  <= pass_nxt;
    end
  end

endmodule

// ----- rtl/core/bpa_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_dp
// Datapath of the page allocator: page bitmap memory, next-fit cursor and
// run counter, write walk, total register and output register.
// ----------------------------------------------------------------------------
module bpa_dp #(
  parameter int MAX_PAGES = bpa_pkg::MAX_PAGES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  input  logic [bpa_pkg::CNT_W-1:0]  cfg_total_pages,
  input  logic [bpa_pkg::PAGE_W-1:0] in_page_index,
  input  logic [bpa_pkg::CNT_W-1:0]  in_count,
  input  logic                       out_stall,
  output logic                       out_valid,
  output logic                       out_ok,
  output logic [bpa_pkg::PAGE_W-1:0] out_base_page,
  input  bpa_pkg::bpa_cmd_t          cmd,
  output bpa_pkg::bpa_sts_t          sts
);
  import bpa_pkg::*;

  localparam int AW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int FW = ((AW > CNT_W) ? AW : CNT_W) + 1;
  localparam logic [CNT_W-1:0] EFF_RST =
    CNT_W'((MAX_PAGES < TOTAL_RST) ? MAX_PAGES : TOTAL_RST);
  localparam logic [FW-1:0] MAP_END = FW'(MAX_PAGES);

  // Page bitmap, 1 = used
  logic mem [MAX_PAGES];

  logic [CNT_W-1:0]  eff_r, eff_nxt;
  logic [CNT_W-1:0]  cursor_r, cursor_nxt;
  logic [CNT_W-1:0]  run_r, run_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [FW-1:0]     page_r, page_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic              fill_bit_r, fill_bit_nxt;
  logic              res_ok_r, res_ok_nxt;
  logic [PAGE_W-1:0] res_first_r, res_first_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_ok_r, out_ok_nxt;
  logic [PAGE_W-1:0] out_first_r, out_first_nxt;
  logic              rd_r;
  logic [CNT_W:0]    probe;
  logic [CNT_W:0]    probe_nxt;
  logic [CNT_W-1:0]  run_inc;
  logic              beyond;
  logic              page_free;

  // Probe of the current cycle; pages at or past the total count as used
  assign probe     = {1'b0, cursor_r} + {1'b0, run_r};
  assign beyond    = (probe >= {1'b0, eff_r});
  assign page_free = !beyond && !rd_r;
  assign run_inc   = run_r + CNT_W'(1);

  // Status
  assign sts.scan_fail = (cursor_r >= eff_r);
  assign sts.scan_hit  = page_free && (run_inc == cnt_r);
  assign sts.fill_end  = (page_r >= MAP_END);
  assign sts.rem_zero  = (rem_r == '0);
  assign sts.cnt_zero  = (in_count == '0);
  assign sts.out_free  = !out_valid_r || !out_stall;

  // Total register, clipped to the map size
  always_comb begin
    eff_nxt = eff_r;
    if (cfg_valid) begin
      if (32'(cfg_total_pages) > 32'(MAX_PAGES)) begin
        eff_nxt = CNT_W'(MAX_PAGES);
      end else begin
        eff_nxt = cfg_total_pages;
      end
    end
  end

  // Cursor and run
  always_comb begin
    cursor_nxt = cursor_r;
    run_nxt    = run_r;
    cnt_nxt    = cnt_r;
    if (cmd.scan_start) begin
      run_nxt = '0;
      cnt_nxt = in_count;
    end else if (cmd.scan_retry || cmd.cursor_zero) begin
      cursor_nxt = '0;
      run_nxt    = '0;
    end else if (cmd.scan_hit) begin
      cursor_nxt = cursor_r + cnt_r;
      run_nxt    = '0;
    end else if (cmd.scan_step) begin
      if (page_free) begin
        run_nxt = run_inc;
      end else begin
        cursor_nxt = cursor_r + ((run_r == '0) ? CNT_W'(1) : run_r);
        run_nxt    = '0;
      end
    end
  end

  // Read the next probe so its bit lines up with the cursor next cycle
  assign probe_nxt = {1'b0, cursor_nxt} + {1'b0, run_nxt};

  // Write walk: clearing pass, free run or mark of a found run
  always_comb begin
    page_nxt     = page_r;
    rem_nxt      = rem_r;
    fill_bit_nxt = fill_bit_r;
    if (cmd.fill_free) begin
      page_nxt     = FW'(in_page_index);
      rem_nxt      = in_count;
      fill_bit_nxt = 1'b0;
    end else if (cmd.scan_hit) begin
      page_nxt     = FW'(cursor_r);
      rem_nxt      = cnt_r;
      fill_bit_nxt = 1'b1;
    end else if (cmd.fill_step) begin
      page_nxt = page_r + FW'(1);
      rem_nxt  = rem_r - CNT_W'(1);
    end
  end

  // Result and output register
  always_comb begin
    res_ok_nxt    = res_ok_r;
    res_first_nxt = res_first_r;
    out_valid_nxt = out_valid_r;
    out_ok_nxt    = out_ok_r;
    out_first_nxt = out_first_r;
    if (cmd.fill_free) begin
      res_ok_nxt    = 1'b1;
      res_first_nxt = '0;
    end else if (cmd.cursor_zero || cmd.res_fail) begin
      res_ok_nxt    = 1'b0;
      res_first_nxt = '0;
    end else if (cmd.scan_hit) begin
      res_ok_nxt    = 1'b1;
      res_first_nxt = cursor_r[PAGE_W-1:0];
    end
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
      out_ok_nxt    = res_ok_r;
      out_first_nxt = res_first_r;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_ok        = out_ok_r;
  assign out_base_page = out_first_r;

  // Bitmap memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.fill_step) begin
      mem[page_r[AW-1:0]] <= fill_bit_r;
    end
    rd_r <= mem[AW'(probe_nxt)];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_r       <= EFF_RST;
      cursor_r    <= '0;
      page_r      <= '0;
      fill_bit_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      eff_r       <= eff_nxt;
      cursor_r    <= cursor_nxt;
      page_r      <= page_nxt;
      fill_bit_r  <= fill_bit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    run_r       <= run_nxt;
    cnt_r       <= cnt_nxt;
    rem_r       <= rem_nxt;
    res_ok_r    <= res_ok_nxt;
    res_first_r <= res_first_nxt;
    out_ok_r    <= out_ok_nxt;
    out_first_r <= out_first_nxt;
  end

endmodule
